// ----- hw/rtl/sine_range_reduce_polynomial_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sine range reduction and polynomial unit.
// The macros rely on clk and rst_n being visible where they are used.
// ----------------------------------------------------------------------------
`ifndef SINE_RANGE_REDUCE_POLYNOMIAL_UNIT_ASSERT_SVH
`define SINE_RANGE_REDUCE_POLYNOMIAL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define SRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SRP_ASSERT(lbl, prop, msg)
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// srp_pkg
// Types, fixed-point constants and rounding helpers shared by the sine unit.
// ----------------------------------------------------------------------------
package srp_pkg;

    // Width of the polynomial datapath words (Q2.30 with headroom).
    localparam int Q_W    = 34;
    // Width of the registered products.
    localparam int PROD_W = 64;
    // Width of the magnitude of k; |k| never exceeds 41.
    localparam int K_W    = 6;
    // Width of k*pi in Q.48.
    localparam int KPI_W  = 56;
    // Width of the reduced angle in Q.48.
    localparam int XR_W   = 58;
    // Width of the reduced magnitude in Q2.30.
    localparam int M_W    = 31;
    // Number of Horner steps after the innermost coefficient.
    localparam int HORNER_STEPS = 5;

    // 1/pi in unsigned Q0.32 and pi in Q.48.
    localparam logic [31:0]      INV_PI_Q32 = 32'd1367130551;
    localparam logic [KPI_W-1:0] PI_Q48     = 56'd884279719003555;

    // Largest magnitude of k over all angles.
    localparam logic [K_W-1:0]   K_MAX = 6'd41;
    // Upper bound on the reduced magnitude, a little above pi/2 in Q2.30.
    localparam logic [M_W-1:0]   M_MAX = 31'd1700000000;

    // Taylor coefficients in Q2.30.
    localparam logic signed [Q_W-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [Q_W-1:0] C1_Q30  = -34'sd178956971;
    localparam logic signed [Q_W-1:0] C2_Q30  = 34'sd8947849;
    localparam logic signed [Q_W-1:0] C3_Q30  = -34'sd213045;
    localparam logic signed [Q_W-1:0] C4_Q30  = 34'sd2959;
    localparam logic signed [Q_W-1:0] C5_Q30  = -34'sd27;

    // Coefficients added in each Horner step, outermost last.
    localparam logic signed [Q_W-1:0] HORNER_COEF [HORNER_STEPS] =
        '{C4_Q30, C3_Q30, C2_Q30, C1_Q30, ONE_Q30};

    // Input item.
    typedef struct packed {
        logic signed [31:0] angle;
        logic               last;
    } srp_item_t;

    // Result item.
    typedef struct packed {
        logic signed [31:0] sine;
        logic               last_out;
    } srp_result_t;

    // Reduced angle handed from range reduction to the polynomial.
    typedef struct packed {
        logic           last;
        logic           sgn;
        logic [M_W-1:0] m;
    } srp_red_t;

    // Word carried through the polynomial stages.
    typedef struct packed {
        logic                      last;
        logic                      sgn;
        logic [M_W-1:0]            m;
        logic signed [Q_W-1:0]     z;
        logic signed [PROD_W-1:0]  prod;
    } srp_poly_t;

    // Round a Q4.60 product back to Q2.30, halves away from zero.
    function automatic logic signed [Q_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        s = p + 64'd536870912 - {63'd0, p[PROD_W-1]};
        return s[PROD_W-1:30];
    endfunction

    // Signed product of two datapath words; the true result fits 64 bits.
    function automatic logic signed [PROD_W-1:0] mul_q(input logic signed [Q_W-1:0] a,
                                                       input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] full;
        full = a * b;
        return full[PROD_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/srp_reduce.sv -----
// ----------------------------------------------------------------------------
// srp_reduce
// Three-stage range reduction: k = round(angle/pi), xr = angle - k*pi,
// and the rounded magnitude of xr in Q2.30 with the final sign.
// ----------------------------------------------------------------------------
`include "sine_range_reduce_polynomial_unit_assert.svh"

module srp_reduce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  srp_pkg::srp_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output srp_pkg::srp_red_t  out_red
);
    import srp_pkg::*;

    logic                   s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                   s1_ready, s2_ready, s3_ready;

    logic [8:0]             s1_ptop_reg, s1_ptop_next;
    logic signed [31:0]     s1_angle_reg;
    logic                   s1_last_reg;

    logic [K_W-1:0]         s2_kmag_reg, s2_kmag_next;
    logic [KPI_W-1:0]       s2_kpi_reg, s2_kpi_next;
    logic signed [31:0]     s2_angle_reg;
    logic                   s2_last_reg;

    srp_red_t               s3_red_reg, s3_red_next;

    logic [31:0]            s1_abs;
    logic [63:0]            s1_prod;
    logic [9:0]             s2_round;
    logic signed [XR_W-1:0] s3_xs, s3_xr;
    logic [XR_W-1:0]        s3_axr, s3_msum;

    // Stage handshake: a stage takes a new item when empty or draining.
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: magnitude of the angle times 1/pi.
    always_comb
    begin
        s1_abs       = in_item.angle[31] ? (~in_item.angle + 32'd1) : in_item.angle;
        s1_prod      = {32'd0, s1_abs} * {32'd0, INV_PI_Q32};
        s1_ptop_next = s1_prod[63:55];
    end

    // Stage 2: round to the nearest integer and form |k|*pi.
    always_comb
    begin
        s2_round     = {1'b0, s1_ptop_reg} + 10'd1;
        s2_kmag_next = s2_round[K_W:1];
        s2_kpi_next  = {{(KPI_W-K_W){1'b0}}, s2_kmag_next} * PI_Q48;
    end

    // Stage 3: subtract k*pi with the sign of the angle, then round to Q2.30.
    always_comb
    begin
        s3_xs  = {{2{s2_angle_reg[31]}}, s2_angle_reg, 24'd0};
        if (s2_angle_reg[31])
            s3_xr = s3_xs + $signed({2'b00, s2_kpi_reg});
        else
            s3_xr = s3_xs - $signed({2'b00, s2_kpi_reg});
        s3_axr  = s3_xr[XR_W-1] ? (~s3_xr + 58'd1) : s3_xr;
        s3_msum = s3_axr + 58'd131072;
        s3_red_next.m    = s3_msum[M_W+17:18];
        s3_red_next.sgn  = s3_xr[XR_W-1] ^ s2_kmag_reg[0];
        s3_red_next.last = s2_last_reg;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers, loaded only when a valid item moves in.
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_ptop_reg  <= s1_ptop_next;
            s1_angle_reg <= in_item.angle;
            s1_last_reg  <= in_item.last;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_kmag_reg  <= s2_kmag_next;
            s2_kpi_reg   <= s2_kpi_next;
            s2_angle_reg <= s1_angle_reg;
            s2_last_reg  <= s1_last_reg;
        end
        if (s2_valid_reg && s3_ready)
            s3_red_reg <= s3_red_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_red   = s3_red_reg;

    `SRP_ASSERT(a_kmag_range, s2_valid_reg |-> (s2_kmag_reg <= K_MAX), "k out of range")
    `SRP_ASSERT(a_m_range, s3_valid_reg |-> (s3_red_reg.m <= M_MAX), "reduced angle beyond pi/2")
    `SRP_ASSERT_NEXT(a_take, in_valid && s1_ready, s1_valid_reg, "accepted item not held")

endmodule

// ----- hw/rtl/srp_square.sv -----
// ----------------------------------------------------------------------------
// srp_square
// Two stages: squares the reduced magnitude, then rounds z = m^2 and
// starts the Horner chain with z times the innermost coefficient.
// ----------------------------------------------------------------------------
module srp_square (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  srp_pkg::srp_red_t  in_red,
    output logic               out_valid,
    input  logic               out_ready,
    output srp_pkg::srp_poly_t out_poly
);
    import srp_pkg::*;

    logic              s4_valid_reg, s5_valid_reg;
    logic              s4_ready, s5_ready;
    srp_poly_t         s4_reg, s4_next;
    srp_poly_t         s5_reg, s5_next;
    logic [2*M_W-1:0]  s4_sq;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    // Stage 4: m squared, exact.
    always_comb
    begin
        s4_sq         = in_red.m * in_red.m;
        s4_next.last  = in_red.last;
        s4_next.sgn   = in_red.sgn;
        s4_next.m     = in_red.m;
        s4_next.z     = '0;
        s4_next.prod  = $signed({2'b00, s4_sq});
    end

    // Stage 5: round z and multiply by the innermost coefficient.
    always_comb
    begin
        s5_next      = s4_reg;
        s5_next.z    = rnd_q30(s4_reg.prod);
        s5_next.prod = mul_q(s5_next.z, C5_Q30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
                s4_valid_reg <= in_valid;
            if (s5_ready)
                s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s4_ready)
            s4_reg <= s4_next;
        if (s4_valid_reg && s5_ready)
            s5_reg <= s5_next;
    end

    assign out_valid = s5_valid_reg;
    assign out_poly  = s5_reg;

endmodule

// ----- hw/rtl/srp_horner_stage.sv -----
// ----------------------------------------------------------------------------
// srp_horner_stage
// One Horner step: rounds the incoming product, adds a coefficient and
// multiplies by the chosen operand (z, or m for the final step).
// ----------------------------------------------------------------------------
module srp_horner_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  srp_pkg::srp_poly_t               in_poly,
    input  logic signed [srp_pkg::Q_W-1:0]   coef,
    input  logic signed [srp_pkg::Q_W-1:0]   mult_op,
    output logic                             out_valid,
    input  logic                             out_ready,
    output srp_pkg::srp_poly_t               out_poly
);
    import srp_pkg::*;

    logic                  valid_reg;
    srp_poly_t             poly_reg, poly_next;
    logic signed [Q_W-1:0] y;

    assign in_ready = !valid_reg || out_ready;

    // y = round(prod) + coef, then the next product.
    always_comb
    begin
        y              = rnd_q30(in_poly.prod) + coef;
        poly_next      = in_poly;
        poly_next.prod = mul_q(mult_op, y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            poly_reg <= poly_next;
    end

    assign out_valid = valid_reg;
    assign out_poly  = poly_reg;

endmodule

// ----- hw/rtl/srp_output.sv -----
// ----------------------------------------------------------------------------
// srp_output
// Output register: rounds the final product, saturates to [-1, 1] and
// applies the sign of the reduced angle combined with the parity of k.
// ----------------------------------------------------------------------------
`include "sine_range_reduce_polynomial_unit_assert.svh"

module srp_output (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  srp_pkg::srp_poly_t   in_poly,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srp_pkg::srp_result_t out_result
);
    import srp_pkg::*;

    logic                  valid_reg;
    srp_result_t           result_reg, result_next;
    logic signed [Q_W-1:0] v, sat, sat_neg;

    assign in_ready = !valid_reg || out_ready;

    // Round, clamp and sign.
    always_comb
    begin
        v = rnd_q30(in_poly.prod);
        if (v > ONE_Q30)
            sat = ONE_Q30;
        else if (v < -ONE_Q30)
            sat = -ONE_Q30;
        else
            sat = v;
        sat_neg = -sat;
        result_next.sine     = in_poly.sgn ? sat_neg[31:0] : sat[31:0];
        result_next.last_out = in_poly.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            result_reg <= result_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    `SRP_ASSERT(a_sine_high, valid_reg |-> (result_reg.sine <= ONE_Q30), "sine above one")
    `SRP_ASSERT(a_sine_low, valid_reg |-> (result_reg.sine >= -ONE_Q30), "sine below minus one")

endmodule

// ----- hw/rtl/sine_range_reduce_polynomial_unit.sv -----
// ----------------------------------------------------------------------------
// sine_range_reduce_polynomial_unit
// Fixed-point sine: range reduction by pi and a degree-11 odd polynomial.
// ----------------------------------------------------------------------------
// The unit takes one angle per cycle in radians (signed Q8.24) when the
// output side is not stalled and returns its sine in signed Q2.30, clamped
// to [-1, 1]; the last flag rides along unchanged. It is a fully pipelined
// datapath of eleven register stages, so new items enter while earlier ones
// are still in flight. Each stage holds at most one 32-by-32 class
// multiplier: three stages reduce the angle, two square it, five run
// the Horner steps and one rounds and signs the result. A stall holds
// the pipeline in place, and bubbles are squeezed out.
// ----------------------------------------------------------------------------
module sine_range_reduce_polynomial_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  srp_pkg::srp_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output srp_pkg::srp_result_t result
);
    import srp_pkg::*;

    logic      red_valid, red_ready;
    srp_red_t  red;

    logic      poly_valid [HORNER_STEPS+1];
    logic      poly_ready [HORNER_STEPS+1];
    srp_poly_t poly       [HORNER_STEPS+1];

    // Range reduction.
    srp_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_ready  (item_ready),
        .in_item   (item),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_red   (red)
    );

    // Square and innermost coefficient.
    srp_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .in_red    (red),
        .out_valid (poly_valid[0]),
        .out_ready (poly_ready[0]),
        .out_poly  (poly[0])
    );

    // Horner chain; the final step multiplies by m instead of z.
    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_horner
        logic signed [Q_W-1:0] op;

        if (i == HORNER_STEPS - 1)
        begin : g_by_m
            assign op = $signed({{(Q_W-M_W){1'b0}}, poly[i].m});
        end
        else
        begin : g_by_z
            assign op = poly[i].z;
        end

        srp_horner_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (poly_valid[i]),
            .in_ready  (poly_ready[i]),
            .in_poly   (poly[i]),
            .coef      (HORNER_COEF[i]),
            .mult_op   (op),
            .out_valid (poly_valid[i+1]),
            .out_ready (poly_ready[i+1]),
            .out_poly  (poly[i+1])
        );
    end

    // Rounding, clamping and sign.
    srp_output u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (poly_valid[HORNER_STEPS]),
        .in_ready   (poly_ready[HORNER_STEPS]),
        .in_poly    (poly[HORNER_STEPS]),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .out_result (result)
    );

endmodule
